>>> hdl/aes128_block_cipher_macros.svh
// Assertion macros used by the checker file.
`ifndef AES128_BLOCK_CIPHER_MACROS_SVH
`define AES128_BLOCK_CIPHER_MACROS_SVH

// Implication checked on every edge outside reset.
`define AES_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define AES_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> hdl/aes_pkg.sv
package aes_pkg;

  typedef logic [7:0] byte_t;
  typedef logic [127:0] block_t;

  typedef enum logic {
    CMD_ENC = 1'b0,
    CMD_DEC = 1'b1
  } cmd_t;

  localparam int unsigned NUM_ROUNDS = 10;

  // Configuration register indexes
  localparam logic REG_KEY_HIGH = 1'b0;
  localparam logic REG_KEY_LOW  = 1'b1;

  // Item moving down the round pipeline
  typedef struct packed {
    logic   valid;
    logic   dec;
    block_t state;
  } stage_t;

  function automatic byte_t xtime(input byte_t a);
    xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] ISBOX [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  // Round constants for rounds 1..10 (index 0 unused)
  localparam logic [7:0] RCON [11] = '{
    8'h00,8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
  };

  // Byte i of a block (byte 0 in the top bits)
  function automatic byte_t get_byte(input block_t b, input int i);
    get_byte = b[127 - 8*i -: 8];
  endfunction

  function automatic block_t byte_subst(input block_t b, input logic inv);
    block_t r;
    for (int i = 0; i < 16; i++) begin
      r[127 - 8*i -: 8] = inv ? ISBOX[get_byte(b, i)] : SBOX[get_byte(b, i)];
    end
    byte_subst = r;
  endfunction

  function automatic block_t row_rotate(input block_t b, input logic inv);
    block_t r;
    for (int c = 0; c < 4; c++) begin
      for (int w = 0; w < 4; w++) begin
        r[127 - 8*(4*c + w) -: 8] =
          get_byte(b, 4*(inv ? ((c - w + 4) & 3) : ((c + w) & 3)) + w);
      end
    end
    row_rotate = r;
  endfunction

  function automatic block_t mix_cols(input block_t b);
    block_t r;
    byte_t a0, a1, a2, a3;
    for (int c = 0; c < 4; c++) begin
      a0 = get_byte(b, 4*c);
      a1 = get_byte(b, 4*c + 1);
      a2 = get_byte(b, 4*c + 2);
      a3 = get_byte(b, 4*c + 3);
      r[127 - 32*c -: 8]  = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
      r[119 - 32*c -: 8]  = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
      r[111 - 32*c -: 8]  = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
      r[103 - 32*c -: 8]  = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
    end
    mix_cols = r;
  endfunction

  // Inverse mix: premultiply by {04}x^2+{05}, then forward mix
  function automatic block_t inv_mix_cols(input block_t b);
    block_t p;
    byte_t u, v;
    for (int c = 0; c < 4; c++) begin
      u = xtime(xtime(get_byte(b, 4*c) ^ get_byte(b, 4*c + 2)));
      v = xtime(xtime(get_byte(b, 4*c + 1) ^ get_byte(b, 4*c + 3)));
      p[127 - 32*c -: 8] = get_byte(b, 4*c) ^ u;
      p[119 - 32*c -: 8] = get_byte(b, 4*c + 1) ^ v;
      p[111 - 32*c -: 8] = get_byte(b, 4*c + 2) ^ u;
      p[103 - 32*c -: 8] = get_byte(b, 4*c + 3) ^ v;
    end
    inv_mix_cols = mix_cols(p);
  endfunction

  // Next round key from the previous one
  function automatic block_t next_round_key(input block_t k, input byte_t rc);
    logic [31:0] t;
    block_t r;
    t = {SBOX[k[23:16]] ^ rc, SBOX[k[15:8]], SBOX[k[7:0]], SBOX[k[31:24]]};
    r[127:96] = k[127:96] ^ t;
    r[95:64]  = k[95:64] ^ r[127:96];
    r[63:32]  = k[63:32] ^ r[95:64];
    r[31:0]   = k[31:0] ^ r[63:32];
    next_round_key = r;
  endfunction

endpackage

>>> hdl/aes_stream_if.sv
interface aes_stream_if #(
  parameter int unsigned W = 1
);
  logic         valid;
  logic         ready;
  logic [W-1:0] payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

>>> hdl/aes128_block_cipher.sv
// Channel   Dir  Payload                            Transfer
// in_       in   cmd, data_high, data_low           valid & ready
// out_      out  result_high, result_low            valid & ready
// cfg_      in   key_high @0x0, key_low @0x8 (APB)  psel & penable & pwrite
// Pipeline: one key-add stage, then ten round stages, one item per cycle while the output is not stalled.
// The pipeline advances whenever the last stage is empty or taken, so a stall
// freezes all stages; ready is high whenever the output register can move.
// Reset clears all valid bits; key schedule holds the expanded schedule of the all-zero key.
// After a key write the round keys are rebuilt in order; the idle window is kept by the user, not the block.
module aes128_block_cipher (
  input  logic                 clk,
  input  logic                 rst_n,
  aes_stream_if.sink           in_ch,
  aes_stream_if.source         out_ch,
  input  logic                 cfg_psel,
  input  logic                 cfg_penable,
  input  logic                 cfg_pwrite,
  input  logic [3:0]           cfg_paddr,
  input  logic [63:0]          cfg_pwdata,
  output logic [63:0]          cfg_prdata,
  output logic                 cfg_pready
);
  import aes_pkg::*;

  logic [63:0]        key_high_r, key_low_r;
  logic               wr, reg_sel;
  logic [11*128-1:0]  rks;
  logic               adv;
  stage_t             st0_r;
  stage_t             st [11];

  // Configuration registers
  assign cfg_pready = 1'b1;
  assign wr = cfg_psel & cfg_penable & cfg_pwrite;
  assign reg_sel = cfg_paddr[3];
  assign cfg_prdata = (cfg_paddr[2:0] != 3'd0 || cfg_paddr[3] == 1'b0) ?
                      ((cfg_paddr == 4'd0) ? key_high_r : 64'd0) : key_low_r;

  logic key_we_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_high_r <= '0;
      key_low_r  <= '0;
      key_we_r   <= 1'b0;
    end else begin
      key_we_r <= 1'b0;
      if (wr && cfg_paddr[2:0] == 3'd0) begin
        key_we_r <= 1'b1;
        unique case (reg_sel)
          REG_KEY_HIGH: key_high_r <= cfg_pwdata;
          REG_KEY_LOW:  key_low_r  <= cfg_pwdata;
          default:      key_low_r  <= key_low_r;
        endcase
      end
    end
  end

  aes_key_sched u_ks (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (key_we_r),
    .cfg_key    ({key_high_r, key_low_r}),
    .round_keys (rks)
  );

  // Whole pipeline moves together
  assign adv = !st[10].valid || out_ch.ready;
  assign in_ch.ready = adv;

  // Stage 0: initial key add
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st0_r.valid <= 1'b0;
    end else if (adv) begin
      st0_r.valid <= in_ch.valid;
    end
    if (adv) begin
      st0_r.dec   <= in_ch.payload[128];
      st0_r.state <= in_ch.payload[127:0] ^
                     (in_ch.payload[128] ? rks[128*10 +: 128] : rks[127:0]);
    end
  end
  assign st[0] = st0_r;

  // Round stages
  for (genvar r = 1; r <= 10; r++) begin : g_rnd
    aes_round u_rnd (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (adv),
      .last    (r == 10),
      .key_enc (rks[128*r +: 128]),
      .key_dec (rks[128*(10-r) +: 128]),
      .d       (st[r-1]),
      .q_r     (st[r])
    );
  end

  assign out_ch.valid   = st[10].valid;
  assign out_ch.payload = st[10].state;
endmodule

>>> hdl/aes_key_sched.sv
// Round key store: loads the key after each write, then expands it one round key at a time.
module aes_key_sched (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [127:0]               cfg_key,
  output logic [11*128-1:0]          round_keys
);
  import aes_pkg::*;

  block_t    rk_r  [11];
  logic [3:0] cnt_r;

  // Round 0 is the key; the rest step one per cycle after a write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 4'd11;
      for (int i = 0; i < 11; i++) begin
        rk_r[i] <= '0;
      end
      rk_r[1]  <= 128'h62636363626363636263636362636363;
      rk_r[2]  <= 128'h9b9898c9f9fbfbaa9b9898c9f9fbfbaa;
      rk_r[3]  <= 128'h90973450696ccffaf2f457330b0fac99;
      rk_r[4]  <= 128'hee06da7b876a1581759e42b27e91ee2b;
      rk_r[5]  <= 128'h7f2e2b88f8443e098dda7cbbf34b9290;
      rk_r[6]  <= 128'hec614b851425758c99ff09376ab49ba7;
      rk_r[7]  <= 128'h217517873550620bacaf6b3cc61bf09b;
      rk_r[8]  <= 128'h0ef903333ba9613897060a04511dfa9f;
      rk_r[9]  <= 128'hb1d4d8e28a7db9da1d7bb3de4c664941;
      rk_r[10] <= 128'hb4ef5bcb3e92e21123e951cf6f8f188e;
    end else if (cfg_we) begin
      rk_r[0] <= cfg_key;
      cnt_r   <= 4'd1;
    end else if (cnt_r != 4'd11) begin
      rk_r[cnt_r] <= next_round_key(rk_r[cnt_r - 4'd1], RCON[cnt_r]);
      cnt_r       <= cnt_r + 4'd1;
    end
  end

  always_comb begin
    for (int i = 0; i < 11; i++) begin
      round_keys[128*i +: 128] = rk_r[i];
    end
  end
endmodule

>>> hdl/aes_round.sv
// One registered cipher round, shared by both directions.
module aes_round (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  last,
  input  logic [127:0]          key_enc,
  input  logic [127:0]          key_dec,
  input  aes_pkg::stage_t       d,
  output aes_pkg::stage_t       q_r
);
  import aes_pkg::*;

  block_t s_sub, s_enc, s_dec, s_nxt;

  // Encrypt: shift, sub, mix, add. Decrypt: shift, sub, add, mix. The last round skips mix.
  always_comb begin
    s_sub = byte_subst(row_rotate(d.state, d.dec), d.dec);
    s_enc = (last ? s_sub : mix_cols(s_sub)) ^ key_enc;
    s_dec = last ? (s_sub ^ key_dec) : inv_mix_cols(s_sub ^ key_dec);
    s_nxt = d.dec ? s_dec : s_enc;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r.valid <= 1'b0;
    end else if (en) begin
      q_r.valid <= d.valid;
    end
    if (en) begin
      q_r.dec   <= d.dec;
      q_r.state <= s_nxt;
    end
  end
endmodule

>>> hdl/aes_checker.sv
`include "aes128_block_cipher_macros.svh"
// Port-level checks on the cipher top.
module aes_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_valid,
  input logic         in_ready,
  input logic         out_valid,
  input logic         out_ready,
  input logic [127:0] out_payload,
  input logic         cfg_pready
);
  `AES_ASSERT_IMPL(a_pready, clk, rst_n, 1'b1, cfg_pready)
  `AES_ASSERT_IMPL(a_ready_free, clk, rst_n, !out_valid, in_ready)
  `AES_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_payload))
  `AES_ASSERT_IMPL(a_stall, clk, rst_n, out_valid && !out_ready, !in_ready)
endmodule

bind aes128_block_cipher aes_checker u_chk (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_payload (out_ch.payload),
  .cfg_pready  (cfg_pready)
);
